[design/gesture_point_gate_defines.svh]
// ----------------------------------------------------------------------------
// gesture_point_gate_defines
// Assertion macros used by the gesture point gate checker
// ----------------------------------------------------------------------------
`ifndef GESTURE_POINT_GATE_DEFINES_SVH
`define GESTURE_POINT_GATE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define GPG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gesture_point_gate: assertion failed");

// next-cycle implication, disabled during reset
`define GPG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gesture_point_gate: assertion failed");

`endif

[design/gpg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpg_pkg
// Types and constants of the gesture point gate
// ----------------------------------------------------------------------------
package gpg_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_TIMEOUT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISTANCE   = 2'd2;

    // register reset values (min distance held as its square)
    localparam logic [15:0] GAP_TIMEOUT_RST    = 16'd500;
    localparam logic [15:0] POINT_INTERVAL_RST = 16'd10;
    localparam logic [31:0] MIN_DIST_SQ_RST    = 32'd25;

    // item modes
    localparam logic MODE_MOVE = 1'b0;
    localparam logic MODE_POLL = 1'b1;

    localparam int SLOT_OUT_W = 6;

    typedef struct packed {
        logic               mode;
        logic signed [15:0] move_x;
        logic signed [15:0] move_y;
        logic               is_relative;
        logic [31:0]        now_ms;
    } in_item_t;

    typedef struct packed {
        logic                  accepted;
        logic signed [15:0]    point_x;
        logic signed [15:0]    point_y;
        logic [SLOT_OUT_W-1:0] slot;
        logic                  started;
        logic                  ended;
        logic [15:0]           wrap_count;
    } out_item_t;

    typedef struct packed {
        logic [15:0] gap_timeout;
        logic [15:0] point_interval;
        logic [31:0] min_dist_sq;
    } cfg_t;

endpackage

[design/gpg_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpg_stream_if
// Valid/ready channel carrying one beat of payload type T
// ----------------------------------------------------------------------------
interface gpg_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/gpg_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpg_cfg_regs
// Configuration registers; min distance is stored squared at write time
// ----------------------------------------------------------------------------
module gpg_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           we,
    input  logic [gpg_pkg::CFG_IDX_W-1:0]  index,
    input  logic [gpg_pkg::CFG_DATA_W-1:0] data,
    output gpg_pkg::cfg_t                  cfg
);

    logic [15:0] gap_timeout_reg;
    logic [15:0] point_interval_reg;
    logic [31:0] min_dist_sq_reg;
    logic [31:0] data_sq;

    // square of the written distance
    assign data_sq = 32'(data) * 32'(data);

    // register writes, unknown indexes dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_timeout_reg    <= gpg_pkg::GAP_TIMEOUT_RST;
            point_interval_reg <= gpg_pkg::POINT_INTERVAL_RST;
            min_dist_sq_reg    <= gpg_pkg::MIN_DIST_SQ_RST;
        end
        else if (we)
        begin
            unique case (index)
                gpg_pkg::CFG_GAP_TIMEOUT:    gap_timeout_reg    <= data;
                gpg_pkg::CFG_POINT_INTERVAL: point_interval_reg <= data;
                gpg_pkg::CFG_MIN_DISTANCE:   min_dist_sq_reg    <= data_sq;
                default: ;
            endcase
        end
    end

    assign cfg.gap_timeout    = gap_timeout_reg;
    assign cfg.point_interval = point_interval_reg;
    assign cfg.min_dist_sq    = min_dist_sq_reg;

endmodule

[design/gpg_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpg_core
// Gesture state and the per-beat accept decision
// ----------------------------------------------------------------------------
module gpg_core #(
    parameter int SLOTS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  gpg_pkg::in_item_t  item,
    input  gpg_pkg::cfg_t      cfg,
    output gpg_pkg::out_item_t result
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

    logic signed [15:0] run_x_reg, run_x_next;
    logic signed [15:0] run_y_reg, run_y_next;
    logic signed [15:0] prev_x_reg, prev_x_next;
    logic signed [15:0] prev_y_reg, prev_y_next;
    logic [SLOT_W-1:0]  next_slot_reg, next_slot_next;
    logic [15:0]        wraps_reg, wraps_next;
    logic               active_reg, active_next;
    logic [31:0]        last_time_reg, last_time_next;

    logic [31:0]        dt;
    logic               in_window;
    logic               timed_out;
    logic               interval_ok;
    logic signed [15:0] base_x, base_y;
    logic signed [15:0] run_x_new, run_y_new;
    logic [SLOT_W-1:0]  slot_base;
    logic [15:0]        wraps_base;
    logic signed [16:0] dx, dy;
    logic signed [33:0] dx_sq, dy_sq;
    logic [34:0]        d2;
    logic               far_enough;
    logic               take;

    // time since the last accepted point or late move
    assign dt          = item.now_ms - last_time_reg;
    assign in_window   = dt < {16'b0, cfg.gap_timeout};
    assign timed_out   = dt > {16'b0, cfg.gap_timeout};
    assign interval_ok = dt >= {16'b0, cfg.point_interval};

    // gesture start clears position, slot and wraps
    assign base_x     = active_reg ? run_x_reg : '0;
    assign base_y     = active_reg ? run_y_reg : '0;
    assign slot_base  = active_reg ? next_slot_reg : '0;
    assign wraps_base = active_reg ? wraps_reg : '0;

    // running position, wraps in 16 bits
    assign run_x_new = item.is_relative ? base_x + item.move_x : item.move_x;
    assign run_y_new = item.is_relative ? base_y + item.move_y : item.move_y;

    // squared distance to the last stored point
    assign dx    = {run_x_new[15], run_x_new} - {prev_x_reg[15], prev_x_reg};
    assign dy    = {run_y_new[15], run_y_new} - {prev_y_reg[15], prev_y_reg};
    assign dx_sq = dx * dx;
    assign dy_sq = dy * dy;
    assign d2    = {1'b0, dx_sq} + {1'b0, dy_sq};
    assign far_enough = d2 >= {3'b0, cfg.min_dist_sq};

    // a move inside the window into the first slot of the ring is always taken
    assign take = (item.mode == gpg_pkg::MODE_MOVE) && in_window
                  && ((slot_base == '0) || (far_enough && interval_ok));

    // next state and result
    always_comb
    begin
        run_x_next     = run_x_reg;
        run_y_next     = run_y_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        next_slot_next = next_slot_reg;
        wraps_next     = wraps_reg;
        active_next    = active_reg;
        last_time_next = last_time_reg;
        result         = '0;

        if (item.mode == gpg_pkg::MODE_POLL)
        begin
            if (active_reg && timed_out)
            begin
                active_next  = 1'b0;
                result.ended = 1'b1;
            end
        end
        else if (in_window)
        begin
            run_x_next     = run_x_new;
            run_y_next     = run_y_new;
            next_slot_next = slot_base;
            wraps_next     = wraps_base;
            active_next    = 1'b1;
            result.started = !active_reg;
            if (take)
            begin
                prev_x_next     = run_x_new;
                prev_y_next     = run_y_new;
                last_time_next  = item.now_ms;
                result.accepted = 1'b1;
                result.point_x  = run_x_new;
                result.point_y  = run_y_new;
                result.slot     = gpg_pkg::SLOT_OUT_W'(slot_base);
                if (slot_base == LAST_SLOT)
                begin
                    next_slot_next = '0;
                    wraps_next     = (wraps_base == 16'hFFFF) ? wraps_base
                                                              : wraps_base + 16'd1;
                end
                else
                begin
                    next_slot_next = slot_base + SLOT_W'(1);
                end
            end
        end
        else
        begin
            // late move only refreshes the time mark
            last_time_next = item.now_ms;
        end

        result.wrap_count = wraps_next;
    end

    // state update once per processed beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_x_reg     <= '0;
            run_y_reg     <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            next_slot_reg <= '0;
            wraps_reg     <= '0;
            active_reg    <= 1'b0;
            last_time_reg <= '0;
        end
        else if (step)
        begin
            run_x_reg     <= run_x_next;
            run_y_reg     <= run_y_next;
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
            next_slot_reg <= next_slot_next;
            wraps_reg     <= wraps_next;
            active_reg    <= active_next;
            last_time_reg <= last_time_next;
        end
    end

endmodule

[design/gesture_point_gate.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gesture_point_gate
// Decimates timestamped pointer moves into the points of a gesture ring
// ----------------------------------------------------------------------------
// Each beat on in_ch (a move or a poll) gives exactly one beat on out_ch.
// The block takes one beat per clock and keeps that rate as long as out_ch
// is ready. A beat is captured in an input register and goes through the
// decision logic (two 17-bit squares, one add and compare, state update)
// when the result register is free or out_ch is ready; its result is then
// loaded into the result register and appears on out_ch from there. While a
// result waits on out_ch, one more beat fits into the input register; after
// that in_ch.ready stays low until out_ch takes the waiting result.
// min_distance is squared as it is written, so configuration writes take
// effect on the next beat. Slots count modulo SLOTS (64 by default) and are
// reported in 6 bits.
module gesture_point_gate #(
    parameter int SLOTS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    gpg_stream_if.sink                     in_ch,
    gpg_stream_if.source                   out_ch,
    input  logic                           cfg_we,
    input  logic [gpg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gpg_pkg::CFG_DATA_W-1:0] cfg_data
);

    gpg_pkg::cfg_t      cfg;
    gpg_pkg::in_item_t  in_item_reg;
    gpg_pkg::out_item_t out_item_reg;
    gpg_pkg::out_item_t result;
    logic               in_valid_reg;
    logic               out_valid_reg;
    logic               advance;
    logic               step;

    // pipeline flow control
    assign advance     = !out_valid_reg || out_ch.ready;
    assign step        = in_valid_reg && advance;
    assign in_ch.ready = !in_valid_reg || advance;

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_item_reg;

    gpg_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    gpg_core #(
        .SLOTS (SLOTS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (result)
    );

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (step)
            begin
                in_valid_reg <= 1'b0;
            end

            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // beat payload registers
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_item_reg <= in_ch.data;
        end
        if (step)
        begin
            out_item_reg <= result;
        end
    end

endmodule

[design/gpg_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpg_checker
// Port-level assertions on the result channel of the gesture point gate
// ----------------------------------------------------------------------------
`include "gesture_point_gate_defines.svh"

module gpg_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input gpg_pkg::out_item_t out_data
);

    // stalled result beat holds
    `GPG_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

    // a closing poll never stores or starts
    `GPG_ASSERT_SAME(a_end_alone, clk, rst_n, out_valid && out_data.ended, !out_data.accepted && !out_data.started)

    // point and slot read zero unless stored
    `GPG_ASSERT_SAME(a_idle_zero, clk, rst_n, out_valid && !out_data.accepted, out_data.point_x == '0 && out_data.point_y == '0 && out_data.slot == '0)

    // a new gesture stores its first point in slot zero with no wraps
    `GPG_ASSERT_SAME(a_start_first, clk, rst_n, out_valid && out_data.started, out_data.accepted && out_data.slot == '0 && out_data.wrap_count == '0)

endmodule

bind gesture_point_gate gpg_checker u_gpg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the gesture point gate
// ----------------------------------------------------------------------------
// A queue of moves and polls feeds a valid/ready driver. A monitor on the
// input side runs every accepted beat through a cycle-free copy of the
// decimation rules and queues the expected result. The monitor on the
// output side checks each result beat, field by field, against the oldest
// expected result. Both channel sides idle at random. Register settings
// change between phases, only while nothing is in flight.
// ----------------------------------------------------------------------------
module tb_top;
    import gpg_pkg::*;

    localparam int SLOTS       = 64;
    localparam int LATENCY     = 2;
    localparam int PHASE_ITEMS = 150;
    localparam int NUM_PHASES  = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_WAIT    = 18;
    localparam int REPORT_MAX  = 10;

    // index that maps to no register
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // driven copies of all block inputs
    logic                  drv_valid   = 1'b0;
    in_item_t              drv_data    = '0;
    logic                  sink_ready  = 1'b0;
    logic                  cfg_we_r    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index_r = '0;
    logic [CFG_DATA_W-1:0] cfg_data_r  = '0;

    gpg_stream_if #(.T(in_item_t))  in_ch ();
    gpg_stream_if #(.T(out_item_t)) out_ch ();

    assign in_ch.valid  = drv_valid;
    assign in_ch.data   = drv_data;
    assign out_ch.ready = sink_ready;

    gesture_point_gate #(
        .SLOTS(SLOTS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .cfg_we   (cfg_we_r),
        .cfg_index(cfg_index_r),
        .cfg_data (cfg_data_r)
    );

    // clock
    always #1 clk = ~clk;

    // predictor state and register copies
    logic [15:0]        cfg_gap      = GAP_TIMEOUT_RST;
    logic [15:0]        cfg_interval = POINT_INTERVAL_RST;
    logic [15:0]        cfg_min_dist = 16'd5;
    logic signed [15:0] pos_x        = '0;
    logic signed [15:0] pos_y        = '0;
    logic signed [15:0] stored_x     = '0;
    logic signed [15:0] stored_y     = '0;
    int                 slot_ptr     = 0;
    logic [15:0]        wrap_cnt     = '0;
    logic               in_gesture   = 1'b0;
    logic [31:0]        mark_ms      = '0;

    in_item_t  move_queue[$];
    out_item_t expected_points[$];

    // bookkeeping
    logic        in_fire   = 1'b0;
    logic        out_fire  = 1'b0;
    int          fail_cnt  = 0;
    int          reported  = 0;
    int          cycles    = 0;
    int          n_items   = 0;
    int          n_results = 0;
    int          n_points  = 0;
    int          n_starts  = 0;
    int          n_ends    = 0;
    logic [15:0] top_wraps = '0;
    logic [31:0] stim_ms   = 32'd100;

    // one move or poll through the decimation rules
    function automatic out_item_t decimate_point(input in_item_t it);
        out_item_t          r;
        logic [31:0]        dt;
        logic               take;
        longint             dx;
        longint             dy;
        longint unsigned    d2;
        longint unsigned    m2;
        r  = '0;
        dt = it.now_ms - mark_ms;
        if (it.mode == MODE_POLL)
        begin
            if (in_gesture && dt > {16'd0, cfg_gap})
            begin
                in_gesture = 1'b0;
                r.ended    = 1'b1;
            end
        end
        else if (dt < {16'd0, cfg_gap})
        begin
            if (!in_gesture)
            begin
                pos_x      = '0;
                pos_y      = '0;
                slot_ptr   = 0;
                wrap_cnt   = '0;
                in_gesture = 1'b1;
                r.started  = 1'b1;
            end
            pos_x = it.is_relative ? pos_x + it.move_x : it.move_x;
            pos_y = it.is_relative ? pos_y + it.move_y : it.move_y;
            if (slot_ptr == 0)
                take = 1'b1;
            else
            begin
                dx   = longint'(pos_x) - longint'(stored_x);
                dy   = longint'(pos_y) - longint'(stored_y);
                d2   = dx * dx + dy * dy;
                m2   = {48'd0, cfg_min_dist} * {48'd0, cfg_min_dist};
                take = (d2 >= m2) && (dt >= {16'd0, cfg_interval});
            end
            if (take)
            begin
                stored_x   = pos_x;
                stored_y   = pos_y;
                r.accepted = 1'b1;
                r.point_x  = pos_x;
                r.point_y  = pos_y;
                r.slot     = slot_ptr[SLOT_OUT_W-1:0];
                if (slot_ptr + 1 >= SLOTS)
                begin
                    if (wrap_cnt != 16'hFFFF)
                        wrap_cnt = wrap_cnt + 16'd1;
                    slot_ptr = 0;
                end
                else
                    slot_ptr = slot_ptr + 1;
                mark_ms = it.now_ms;
            end
        end
        else
            mark_ms = it.now_ms;
        r.wrap_count = wrap_cnt;
        return r;
    endfunction

    function automatic in_item_t mk_item(input logic mode, input int x, input int y,
                                         input logic rel, input logic [31:0] now);
        in_item_t it;
        it.mode        = mode;
        it.move_x      = x[15:0];
        it.move_y      = y[15:0];
        it.is_relative = rel;
        it.now_ms      = now;
        return it;
    endfunction

    // wait length per beat, with stretches of back-to-back beats
    function automatic int draw_wait(inout bit burst);
        if ($urandom_range(0, 39) == 0)
            burst = !burst;
        return burst ? 0 : int'($urandom_range(0, MAX_WAIT));
    endfunction

    // input driver
    always @(negedge clk)
    begin : drive_in
        static int in_gap   = 0;
        static bit in_burst = 1'b0;
        if (!rst_n)
            drv_valid <= 1'b0;
        else if (!drv_valid || in_fire)
        begin
            if (in_gap != 0)
            begin
                drv_valid <= 1'b0;
                in_gap = in_gap - 1;
            end
            else if (move_queue.size() != 0)
            begin
                drv_data  <= move_queue.pop_front();
                drv_valid <= 1'b1;
                in_gap = draw_wait(in_burst);
            end
            else
                drv_valid <= 1'b0;
        end
    end

    // output stalls, drawn after every result beat
    always @(negedge clk)
    begin : drive_ready
        static int out_stall = 0;
        static bit out_burst = 1'b0;
        if (!rst_n)
            sink_ready <= 1'b0;
        else
        begin
            if (out_fire)
                out_stall = draw_wait(out_burst);
            if (out_stall != 0)
            begin
                sink_ready <= 1'b0;
                out_stall = out_stall - 1;
            end
            else
                sink_ready <= 1'b1;
        end
    end

    // monitors: predict on input beats, check on output beats
    always @(posedge clk)
    begin : monitor
        out_item_t want;
        out_item_t got;
        if (rst_n)
        begin
            in_fire  <= in_ch.valid && in_ch.ready;
            out_fire <= out_ch.valid && out_ch.ready;
            if (in_ch.valid && in_ch.ready)
            begin
                expected_points.push_back(decimate_point(in_ch.data));
                n_items = n_items + 1;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                got       = out_ch.data;
                n_results = n_results + 1;
                if (expected_points.size() == 0)
                begin
                    fail_cnt = fail_cnt + 1;
                    if (reported < REPORT_MAX)
                        $display("unexpected result beat at cycle %0d", cycles);
                    reported = reported + 1;
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (got.accepted !== want.accepted || got.point_x !== want.point_x ||
                        got.point_y !== want.point_y || got.slot !== want.slot ||
                        got.started !== want.started || got.ended !== want.ended ||
                        got.wrap_count !== want.wrap_count)
                    begin
                        fail_cnt = fail_cnt + 1;
                        if (reported < REPORT_MAX)
                        begin
                            $display("mismatch at result %0d, cycle %0d", n_results, cycles);
                            $display("  expected acc %0d x %0d y %0d slot %0d st %0d end %0d wr %0d",
                                     want.accepted, want.point_x, want.point_y, want.slot,
                                     want.started, want.ended, want.wrap_count);
                            $display("  actual   acc %0d x %0d y %0d slot %0d st %0d end %0d wr %0d",
                                     got.accepted, got.point_x, got.point_y, got.slot,
                                     got.started, got.ended, got.wrap_count);
                        end
                        reported = reported + 1;
                    end
                    n_points = n_points + int'(want.accepted);
                    n_starts = n_starts + int'(want.started);
                    n_ends   = n_ends + int'(want.ended);
                    if (want.wrap_count > top_wraps)
                        top_wraps = want.wrap_count;
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_points.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // wait until nothing is queued or in flight
    task automatic drain();
        while (move_queue.size() != 0 || drv_valid || expected_points.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we_r    <= 1'b1;
        cfg_index_r <= idx;
        cfg_data_r  <= val;
        case (idx)
            CFG_GAP_TIMEOUT:    cfg_gap = val;
            CFG_POINT_INTERVAL: cfg_interval = val;
            CFG_MIN_DISTANCE:   cfg_min_dist = val;
            default:            ;
        endcase
        @(negedge clk);
        cfg_we_r <= 1'b0;
    endtask

    // random stimulus: mostly gesture strokes, some polls, late moves, noise
    task automatic add_random_moves(input int n);
        int span;
        int step;
        int kind;
        int x;
        int y;
        span = int'(cfg_min_dist) * 2 + 8;
        if (span > 32767)
            span = 32767;
        for (int i = 0; i < n; i++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 8)
            begin
                stim_ms = $urandom();
                move_queue.push_back(mk_item(1'($urandom_range(0, 1)), $urandom(), $urandom(),
                                             1'($urandom_range(0, 1)), stim_ms));
            end
            else if (kind < 18)
            begin
                case ($urandom_range(0, 3))
                    0:       step = int'(cfg_gap);
                    1:       step = int'(cfg_gap) + 1;
                    2:       step = $urandom_range(0, 20);
                    default: step = $urandom_range(0, 4 * int'(cfg_gap) + 100);
                endcase
                stim_ms = stim_ms + step;
                move_queue.push_back(mk_item(MODE_POLL, $urandom(), $urandom(),
                                             1'($urandom_range(0, 1)), stim_ms));
            end
            else if (kind < 24)
            begin
                stim_ms = stim_ms + int'(cfg_gap) + $urandom_range(0, 40);
                move_queue.push_back(mk_item(MODE_MOVE, $urandom_range(0, 64),
                                             $urandom_range(0, 64), 1'b1, stim_ms));
            end
            else
            begin
                step = $urandom_range(0, int'(cfg_interval) * 2 + 4);
                if (cfg_gap > 16'd1 && step >= int'(cfg_gap))
                    step = $urandom_range(0, int'(cfg_gap) - 1);
                stim_ms = stim_ms + step;
                if ($urandom_range(0, 4) != 0)
                begin
                    x = int'($urandom_range(0, 2 * span)) - span;
                    y = int'($urandom_range(0, 2 * span)) - span;
                    move_queue.push_back(mk_item(MODE_MOVE, x, y, 1'b1, stim_ms));
                end
                else
                    move_queue.push_back(mk_item(MODE_MOVE, $urandom(), $urandom(),
                                                 1'b0, stim_ms));
            end
        end
    endtask

    // main sequence
    initial
    begin
        // directed part at reset settings
        move_queue.push_back(mk_item(MODE_POLL, -1, 32767, 1'b1, 32'd100));
        move_queue.push_back(mk_item(MODE_MOVE, 0, 0, 1'b0, 32'd100));
        // too close, then exactly at the minimum distance
        move_queue.push_back(mk_item(MODE_MOVE, 3, 0, 1'b0, 32'd120));
        move_queue.push_back(mk_item(MODE_MOVE, 3, 4, 1'b0, 32'd140));
        // far enough but too soon
        move_queue.push_back(mk_item(MODE_MOVE, 20, 4, 1'b0, 32'd145));
        // relative move that overflows the running position
        move_queue.push_back(mk_item(MODE_MOVE, 32767, -32768, 1'b1, 32'd200));
        move_queue.push_back(mk_item(MODE_MOVE, 32767, 32767, 1'b0, 32'd210));
        move_queue.push_back(mk_item(MODE_MOVE, -32768, -32768, 1'b0, 32'd220));
        // late move exactly at the timeout, then a move right after it
        move_queue.push_back(mk_item(MODE_MOVE, 100, 100, 1'b0, 32'd720));
        move_queue.push_back(mk_item(MODE_MOVE, 0, 0, 1'b0, 32'd721));
        // poll past the timeout closes the gesture, a second one finds none
        move_queue.push_back(mk_item(MODE_POLL, 0, 0, 1'b0, 32'd1221));
        move_queue.push_back(mk_item(MODE_POLL, 0, 0, 1'b0, 32'd1222));
        move_queue.push_back(mk_item(MODE_MOVE, 5, 5, 1'b1, 32'd1300));
        move_queue.push_back(mk_item(MODE_MOVE, 5, 5, 1'b1, 32'd1310));
        move_queue.push_back(mk_item(MODE_MOVE, -1, -1, 1'b1, 32'd1330));
        // poll exactly at the timeout keeps the gesture, one past it ends it
        move_queue.push_back(mk_item(MODE_POLL, 0, 0, 1'b0, 32'd1810));
        move_queue.push_back(mk_item(MODE_POLL, 0, 0, 1'b0, 32'd1811));
        // timestamp wrapping through zero
        move_queue.push_back(mk_item(MODE_MOVE, 7, 7, 1'b0, 32'hFFFF_FFF0));
        move_queue.push_back(mk_item(MODE_MOVE, 7, 7, 1'b0, 32'h0000_0005));
        move_queue.push_back(mk_item(MODE_MOVE, -1, -1, 1'b1, 32'h0000_0020));
        move_queue.push_back(mk_item(MODE_MOVE, 40, -40, 1'b1, 32'h0000_0040));
        move_queue.push_back(mk_item(MODE_POLL, 0, 0, 1'b0, 32'h8000_0000));
        stim_ms = 32'h8000_0100;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    // everything inside the window is kept: ring wraps
                    write_reg(CFG_GAP_TIMEOUT, 16'hFFFF);
                    write_reg(CFG_POINT_INTERVAL, 16'd0);
                    write_reg(CFG_MIN_DISTANCE, 16'd0);
                end
                1:
                begin
                    // zero timeout: every move is late
                    write_reg(CFG_GAP_TIMEOUT, 16'd0);
                    write_reg(CFG_POINT_INTERVAL, 16'hFFFF);
                    write_reg(CFG_MIN_DISTANCE, 16'hFFFF);
                end
                2:
                begin
                    // only first slots pass, timestamps near the wrap point
                    write_reg(CFG_GAP_TIMEOUT, 16'd1000);
                    write_reg(CFG_MIN_DISTANCE, 16'hFFFF);
                    stim_ms = 32'hFFFF_F000;
                end
                3:
                begin
                    write_reg(CFG_GAP_TIMEOUT, 16'd300);
                    write_reg(CFG_POINT_INTERVAL, 16'd0);
                    write_reg(CFG_MIN_DISTANCE, 16'd0);
                    write_reg(CFG_UNUSED, 16'hFFFF);
                end
                default:
                begin
                    write_reg(CFG_GAP_TIMEOUT, 16'($urandom_range(50, 3000)));
                    write_reg(CFG_POINT_INTERVAL, 16'($urandom_range(0, 60)));
                    write_reg(CFG_MIN_DISTANCE, 16'($urandom_range(0, 200)));
                end
            endcase
            add_random_moves(PHASE_ITEMS);
            drain();
        end

        repeat (LATENCY + 8) @(posedge clk);
        $display("covered %0d beats in %0d phases: %0d points kept, %0d gestures begun",
                 n_items, NUM_PHASES + 1, n_points, n_starts);
        $display("%0d gestures closed by polls, highest wrap count %0d, %0d failures",
                 n_ends, top_wraps, fail_cnt);
        if (fail_cnt == 0 && expected_points.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
